[sv/bcv_pkg.sv]
// Shared types, constants and helpers for the battery charge and voltage model.
// No dependencies; used by every other file of the block.
package bcv_pkg;

    localparam int DATA_W      = 32;
    localparam int CUR_W       = 20;
    localparam int SERIES_W    = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_COEF    = 4;
    localparam int COEF_IDX_W  = 2;
    localparam int MUL_W       = DATA_W + 1;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int WIDE_W      = PROD_W + 6;
    localparam int DEPTH_FRAC  = 24;
    localparam int CAP_FRAC    = 28;
    localparam int HORNER_FRAC = 24;
    localparam int POLY_ORDER_DEF = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF0      = 3'd0,
        REG_COEF1      = 3'd1,
        REG_COEF2      = 3'd2,
        REG_COEF3      = 3'd3,
        REG_SERIES     = 3'd4,
        REG_GAIN       = 3'd5,
        REG_CAP_PP     = 3'd6,
        REG_INIT_DEPTH = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MUL_CHARGE = 2'd0,
        MUL_CAP    = 2'd1,
        MUL_HORNER = 2'd2,
        MUL_PACK   = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic [NUM_COEF-1:0][DATA_W-1:0] coef;
        logic [SERIES_W-1:0]             series;
        logic [DATA_W-1:0]               gain;
        logic [DATA_W-1:0]               cap_pp;
        logic                            depth_load;
        logic [DATA_W-1:0]               depth_init;
    } cfg_t;

    typedef struct packed {
        logic                  load_in;
        logic                  mul_en;
        mul_sel_t              mul_sel;
        logic                  depth_upd;
        logic                  cap_upd;
        logic                  acc_init;
        logic                  acc_upd;
        logic                  out_ld;
        logic [COEF_IDX_W-1:0] coef_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } ctrl_stat_t;

    function automatic logic signed [WIDE_W-1:0] sx_data(input logic [DATA_W-1:0] x);
        return $signed({{(WIDE_W-DATA_W){x[DATA_W-1]}}, x});
    endfunction

    function automatic logic signed [WIDE_W-1:0] sx_prod(input logic [PROD_W-1:0] x);
        return $signed({{(WIDE_W-PROD_W){x[PROD_W-1]}}, x});
    endfunction

    // clamp to the signed 32 bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = $signed({{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
        lo = $signed({{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});
        if (x > hi)
            return hi[DATA_W-1:0];
        else if (x < lo)
            return lo[DATA_W-1:0];
        else
            return x[DATA_W-1:0];
    endfunction

endpackage

[sv/bcv_cfg_regs.sv]
// Configuration register file: curve terms, cell count, gain, capacity scale.
// Depends on bcv_pkg. A write to the initial depth register raises a load strobe.
module bcv_cfg_regs
    import bcv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    logic [NUM_COEF-1:0][DATA_W-1:0] coef_reg;
    logic [NUM_COEF-1:0][DATA_W-1:0] coef_next;
    logic [SERIES_W-1:0]             series_reg;
    logic [SERIES_W-1:0]             series_next;
    logic [DATA_W-1:0]               gain_reg;
    logic [DATA_W-1:0]               gain_next;
    logic [DATA_W-1:0]               cap_pp_reg;
    logic [DATA_W-1:0]               cap_pp_next;
    logic                            depth_load;

    always_comb
    begin
        coef_next   = coef_reg;
        series_next = series_reg;
        gain_next   = gain_reg;
        cap_pp_next = cap_pp_reg;
        depth_load  = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_COEF0, REG_COEF1, REG_COEF2, REG_COEF3:
                    coef_next[cfg_index[COEF_IDX_W-1:0]] = cfg_data;
                REG_SERIES:     series_next = cfg_data[SERIES_W-1:0];
                REG_GAIN:       gain_next   = cfg_data;
                REG_CAP_PP:     cap_pp_next = cfg_data;
                REG_INIT_DEPTH: depth_load  = 1'b1;
                default:        depth_load  = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg   <= '0;
            series_reg <= SERIES_W'(1);
            gain_reg   <= '0;
            cap_pp_reg <= '0;
        end
        else
        begin
            coef_reg   <= coef_next;
            series_reg <= series_next;
            gain_reg   <= gain_next;
            cap_pp_reg <= cap_pp_next;
        end
    end

    assign cfg.coef       = coef_reg;
    assign cfg.series     = series_reg;
    assign cfg.gain       = gain_reg;
    assign cfg.cap_pp     = cap_pp_reg;
    assign cfg.depth_load = depth_load;
    assign cfg.depth_init = cfg_data;

endmodule

[sv/bcv_datapath.sv]
// Datapath: shared 33x33 multiplier, depth state, capacity, Horner accumulator
// and the output register. Depends on bcv_pkg; driven by bcv_ctrl commands.
module bcv_datapath
    import bcv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  ctrl_cmd_t            cmd,
    output ctrl_stat_t           stat,
    input  logic [CUR_W-1:0]     charge_current,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [DATA_W-1:0]    pack_voltage,
    output logic [DATA_W-1:0]    depth_of_discharge
);

    localparam logic signed [WIDE_W-1:0] RND_DEPTH  = WIDE_W'(1) <<< (DEPTH_FRAC - 1);
    localparam logic signed [WIDE_W-1:0] RND_CAP    = WIDE_W'(1) <<< (CAP_FRAC - 1);
    localparam logic signed [WIDE_W-1:0] RND_HORNER = WIDE_W'(1) <<< (HORNER_FRAC - 1);

    logic [CUR_W-1:0]         cur_reg;
    logic [DATA_W-1:0]        depth_reg;
    logic [DATA_W-1:0]        depth_next;
    logic [DATA_W-1:0]        cap_reg;
    logic [DATA_W-1:0]        acc_reg;
    logic [DATA_W-1:0]        acc_next;
    logic [PROD_W-1:0]        prod_reg;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [WIDE_W-1:0] prod_wide;
    logic signed [WIDE_W-1:0] dep_sum;
    logic signed [WIDE_W-1:0] cap_sum;
    logic signed [WIDE_W-1:0] hor_sum;
    logic [DATA_W-1:0]        coef_sel;
    logic                     out_valid_reg;
    logic [DATA_W-1:0]        volt_reg;
    logic [DATA_W-1:0]        dod_reg;

    // multiplier operand selection
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_CHARGE:
            begin
                mul_a = $signed({{(MUL_W-CUR_W){cur_reg[CUR_W-1]}}, cur_reg});
                mul_b = $signed({1'b0, cfg.gain});
            end
            MUL_CAP:
            begin
                mul_a = $signed({depth_reg[DATA_W-1], depth_reg});
                mul_b = $signed({1'b0, cfg.cap_pp});
            end
            MUL_HORNER:
            begin
                mul_a = $signed({acc_reg[DATA_W-1], acc_reg});
                mul_b = $signed({cap_reg[DATA_W-1], cap_reg});
            end
            MUL_PACK:
            begin
                mul_a = $signed({acc_reg[DATA_W-1], acc_reg});
                mul_b = $signed({{(MUL_W-SERIES_W){1'b0}}, cfg.series});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // full-width signed product
    assign mul_p     = mul_a * mul_b;
    assign coef_sel  = cfg.coef[cmd.coef_sel];
    assign prod_wide = sx_prod(prod_reg);

    // round to nearest, ties upward: add half then arithmetic shift
    assign dep_sum = ((sx_data(depth_reg) <<< DEPTH_FRAC) - prod_wide + RND_DEPTH)
                     >>> DEPTH_FRAC;
    assign cap_sum = (prod_wide + RND_CAP) >>> CAP_FRAC;
    assign hor_sum = ((prod_wide + RND_HORNER) >>> HORNER_FRAC) + sx_data(coef_sel);

    always_comb
    begin
        depth_next = depth_reg;
        if (cfg.depth_load)
            depth_next = cfg.depth_init;
        else if (cmd.depth_upd)
            depth_next = sat32(dep_sum);
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_init)
            acc_next = coef_sel;
        else if (cmd.acc_upd)
            acc_next = sat32(hor_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            if (cmd.out_ld)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            cur_reg <= charge_current;
        if (cmd.mul_en)
            prod_reg <= mul_p;
        if (cmd.cap_upd)
            cap_reg <= sat32(cap_sum);
        acc_reg <= acc_next;
        if (cmd.out_ld)
        begin
            volt_reg <= sat32(prod_wide);
            dod_reg  <= depth_reg;
        end
    end

    assign stat.out_free      = !out_valid_reg || out_ready;
    assign out_valid          = out_valid_reg;
    assign pack_voltage       = volt_reg;
    assign depth_of_discharge = dod_reg;

endmodule

[sv/bcv_ctrl.sv]
// Sequencer for one tick: charge product, depth update, capacity, Horner loop,
// pack scaling, hand-off to the output register. Depends on bcv_pkg.
module bcv_ctrl
    import bcv_pkg::*;
#(
    parameter int POLY_ORDER = POLY_ORDER_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_CUR  = 9'b000000010,
        ST_DEP  = 9'b000000100,
        ST_CAP  = 9'b000001000,
        ST_CAPR = 9'b000010000,
        ST_HMUL = 9'b000100000,
        ST_HADD = 9'b001000000,
        ST_VMUL = 9'b010000000,
        ST_OUT  = 9'b100000000
    } state_t;

    localparam logic [COEF_IDX_W-1:0] TOP_IDX = COEF_IDX_W'(POLY_ORDER);
    localparam logic [COEF_IDX_W-1:0] NXT_IDX = COEF_IDX_W'(POLY_ORDER - 1);

    state_t                state_reg;
    state_t                state_next;
    logic [COEF_IDX_W-1:0] k_reg;
    logic [COEF_IDX_W-1:0] k_next;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_CHARGE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CUR;
                end
            end
            ST_CUR:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CHARGE;
                state_next  = ST_DEP;
            end
            ST_DEP:
            begin
                cmd.depth_upd = 1'b1;
                state_next    = ST_CAP;
            end
            ST_CAP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CAP;
                state_next  = ST_CAPR;
            end
            ST_CAPR:
            begin
                cmd.cap_upd  = 1'b1;
                cmd.acc_init = 1'b1;
                cmd.coef_sel = TOP_IDX;
                if (POLY_ORDER == 0)
                    state_next = ST_VMUL;
                else
                begin
                    k_next     = NXT_IDX;
                    state_next = ST_HMUL;
                end
            end
            ST_HMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_HORNER;
                state_next  = ST_HADD;
            end
            ST_HADD:
            begin
                cmd.acc_upd  = 1'b1;
                cmd.coef_sel = k_reg;
                if (k_reg == '0)
                    state_next = ST_VMUL;
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = ST_HMUL;
                end
            end
            ST_VMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PACK;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

[sv/battery_charge_and_voltage_model.sv]
// Top level of the battery charge and voltage model (coulomb counter plus cubic curve).
// Depends on bcv_pkg, bcv_cfg_regs, bcv_ctrl and bcv_datapath.
//
// Use:
//  - Input channel (in_valid/in_ready, charge_current): one beat per tick, signed mA,
//    positive when charging.
//  - Output channel (out_valid/out_ready, pack_voltage, depth_of_discharge): one beat
//    per input beat, in order. Voltage is Q16.16 V, depth Q8.24 percent, both clamped.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready; writes
//    take effect at the accepting edge. Writing initial_depth also loads the depth.
//    Write only while no tick is in flight.
//  - Sequence: from the accepting edge to out_valid the work is ordered by the single
//    shared multiplier: the charge product, capacity product, one product per Horner
//    step and the cell-count product are each formed into the product register and
//    then applied in a step of its own; the result then goes to the output register.
//  - Ticks are worked on one at a time; a new tick is taken as soon as the
//    previous result is in the output register.
//  - Stall: while out_ready is low a finished result waits in the output register and
//    the next tick is accepted and worked on; it then holds before its last step.
//  - Reset: depth and curve terms clear, series count becomes one, no output pending.
module battery_charge_and_voltage_model
    import bcv_pkg::*;
#(
    parameter int POLY_ORDER = POLY_ORDER_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CUR_W-1:0]     charge_current,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_W-1:0]    pack_voltage,
    output logic [DATA_W-1:0]    depth_of_discharge,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // register file never stalls a config beat
    assign cfg_ready = 1'b1;

    bcv_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // one-hot sequencer; owns the input handshake
    bcv_ctrl #(
        .POLY_ORDER (POLY_ORDER)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and output register; owns the output handshake
    bcv_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .cmd                (cmd),
        .stat               (stat),
        .charge_current     (charge_current),
        .out_ready          (out_ready),
        .out_valid          (out_valid),
        .pack_voltage       (pack_voltage),
        .depth_of_discharge (depth_of_discharge)
    );

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for battery_charge_and_voltage_model: coulomb counting and cubic curve.
// Needs bcv_pkg and the block's RTL; an in-bench predictor tracks depth and works out each beat.
module tb_top
    import bcv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 27;
    localparam int HOLD_CYCLES = 250;
    localparam int TAIL_CYCLES = 20;

    // one output beat: pack voltage and updated depth
    typedef struct packed {
        logic [DATA_W-1:0] volts;
        logic [DATA_W-1:0] depth;
    } pack_reading_t;

    logic                 clk;
    logic                 rst_n          = 1'b0;
    logic                 in_valid       = 1'b0;
    logic                 in_ready;
    logic [CUR_W-1:0]     charge_current = '0;
    logic                 out_valid;
    logic                 out_ready      = 1'b0;
    logic [DATA_W-1:0]    pack_voltage;
    logic [DATA_W-1:0]    depth_of_discharge;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [DATA_W-1:0]    cfg_data       = '0;

    // predictor's own copy of the registers and the depth state
    logic signed [DATA_W-1:0]   curve_coef [NUM_COEF];
    logic [SERIES_W-1:0]        cells_in_series;
    logic [DATA_W-1:0]          gain_per_ma;
    logic [DATA_W-1:0]          ah_per_percent;
    logic signed [DATA_W-1:0]   tracked_depth;

    pack_reading_t expected_readings [$];
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  no_gaps        = 1'b0;   // both sides run flat out while set
    bit  hold_req       = 1'b0;   // asks the receiver for one long hold-off
    int  hold_left      = 0;

    battery_charge_and_voltage_model u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .charge_current     (charge_current),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .pack_voltage       (pack_voltage),
        .depth_of_discharge (depth_of_discharge),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor arithmetic. All rescaling rounds half up (add half, floor).
    // Products fit in 64 bits: worst is depth (s32) times capacity/% (u32).
    // ------------------------------------------------------------------
    function automatic longint round_half_up(input longint x, input int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_s32(input longint x);
        if (x > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        else if (x < -longint'(64'sh8000_0000))
            return 32'sh8000_0000;
        else
            return x[DATA_W-1:0];
    endfunction

    // advances the tracked depth by one tick, then works out the pack reading
    function automatic pack_reading_t predict_reading(input logic signed [CUR_W-1:0] cur);
        pack_reading_t            r;
        longint                   wide;
        logic signed [DATA_W-1:0] cap_ah;
        logic signed [DATA_W-1:0] acc;
        int                       k;
        // coulomb counting, 2^-48 percent units; charging lowers the depth
        wide = longint'(tracked_depth) * (longint'(1) <<< DEPTH_FRAC)
             - longint'(cur) * longint'({32'd0, gain_per_ma});
        tracked_depth = clamp_s32(round_half_up(wide, DEPTH_FRAC));
        // discharged capacity, Q8.24 Ah
        cap_ah = clamp_s32(round_half_up(longint'(tracked_depth)
                                         * longint'({32'd0, ah_per_percent}), CAP_FRAC));
        // Horner from the top term down, clamped at every step
        acc = curve_coef[POLY_ORDER_DEF];
        for (k = POLY_ORDER_DEF - 1; k >= 0; k--)
            acc = clamp_s32(round_half_up(longint'(acc) * longint'(cap_ah), HORNER_FRAC)
                            + longint'(curve_coef[k]));
        r.volts = clamp_s32(longint'(acc) * longint'({56'd0, cells_in_series}));
        r.depth = tracked_depth;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking: each output beat against the oldest expected reading
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        pack_reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_readings.size() == 0)
                report_mismatch("unexpected beat (voltage)", pack_voltage, '0);
            else
            begin
                want = expected_readings.pop_front();
                if (pack_voltage !== want.volts)
                    report_mismatch("pack_voltage", pack_voltage, want.volts);
                if (depth_of_discharge !== want.depth)
                    report_mismatch("depth_of_discharge", depth_of_discharge, want.depth);
            end
        end
    end

    // Receiver: random stalls, a flat-out mode, and one long hold-off on request.
    // The hold-off is counted here so the sender keeps offering ticks meanwhile.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (no_gaps)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Register write; cfg_valid is left high so back-to-back writes need no re-raise.
    task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_COEF0:      curve_coef[0]   = data;
            REG_COEF1:      curve_coef[1]   = data;
            REG_COEF2:      curve_coef[2]   = data;
            REG_COEF3:      curve_coef[3]   = data;
            REG_SERIES:     cells_in_series = data[SERIES_W-1:0];
            REG_GAIN:       gain_per_ma     = data;
            REG_CAP_PP:     ah_per_percent  = data;
            REG_INIT_DEPTH: tracked_depth   = data;
            default: ;
        endcase
    endtask

    task automatic load_curve(input logic [DATA_W-1:0] c0, input logic [DATA_W-1:0] c1,
                              input logic [DATA_W-1:0] c2, input logic [DATA_W-1:0] c3);
        write_reg(REG_COEF0, c0);
        write_reg(REG_COEF1, c1);
        write_reg(REG_COEF2, c2);
        write_reg(REG_COEF3, c3);
    endtask

    // One tick beat. A random gap may drop valid first; otherwise valid stays high
    // from the previous beat, so it is never lowered and raised in one step.
    // A pending config valid is dropped before the gap so no write repeats.
    task automatic send_tick(input logic signed [CUR_W-1:0] cur);
        int            gap;
        pack_reading_t next_reading;
        if (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            gap = $urandom_range(1, 16);
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_valid      <= 1'b0;
        in_valid       <= 1'b1;
        charge_current <= cur;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        next_reading      = predict_reading(cur);
        expected_readings = {expected_readings, next_reading};
    endtask

    // Drop valids and wait for every outstanding reading; the block is idle after.
    task automatic drain();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [CUR_W-1:0] rand_current();
        int v;
        case ($urandom_range(7))
            0: v = -(1 << (CUR_W - 1));
            1: v = (1 << (CUR_W - 1)) - 1;
            2: v = 0;
            3, 4: v = int'($urandom_range(4000)) - 2000;   // everyday currents
            default: v = int'($urandom);
        endcase
        return v[CUR_W-1:0];
    endfunction

    // full-range register word, leaning on the corners
    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset: zero curve and gain, depth sits at zero whatever the current.
    task automatic test_reset_state();
        send_tick(20'sh00000);
        send_tick(20'sh7FFFF);
        send_tick(20'sh80000);
        drain();
    endtask

    // Plausible Li-ion cell, 4 in series, starting half discharged.
    task automatic test_nominal_cell();
        load_curve(32'sd242483, -32'sd13107, 32'sd3277, -32'sd655);
        write_reg(REG_SERIES, 32'd4);
        write_reg(REG_GAIN, 32'd2_800_000);
        write_reg(REG_CAP_PP, 32'd5_368_709);
        write_reg(REG_INIT_DEPTH, 32'sd838860800);   // 50 %
        send_tick(20'sd0);
        send_tick(20'sd1000);
        send_tick(-20'sd1000);
        send_tick(20'sh7FFFF);
        send_tick(20'sh80000);
        drain();
    endtask

    // Depth clamps at both ends; huge curve terms and capacity clamp Horner too.
    task automatic test_depth_clamp();
        load_curve(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        write_reg(REG_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_CAP_PP, 32'hFFFF_FFFF);
        write_reg(REG_INIT_DEPTH, 32'h7F00_0000);
        repeat (3) send_tick(20'sh80000);            // hard discharge: top clamp
        drain();
        write_reg(REG_INIT_DEPTH, 32'h8100_0000);
        repeat (3) send_tick(20'sh7FFFF);            // hard charge: bottom clamp
        drain();
    endtask

    // No cells, zero gain, zero capacity, and a full 255-cell string.
    task automatic test_degenerate_settings();
        load_curve(32'sd242483, 32'sd65536, -32'sd65536, 32'sd1000);
        write_reg(REG_SERIES, 32'd0);
        write_reg(REG_GAIN, 32'd1_000_000);
        write_reg(REG_CAP_PP, 32'd5_000_000);
        write_reg(REG_INIT_DEPTH, 32'sd335544320);   // 20 %
        send_tick(-20'sd5000);
        send_tick(20'sd5000);
        drain();
        // depth holds and the curve collapses to its constant term
        write_reg(REG_SERIES, 32'd3);
        write_reg(REG_GAIN, 32'd0);
        write_reg(REG_CAP_PP, 32'd0);
        send_tick(20'sh80000);
        send_tick(20'sh7FFFF);
        drain();
        write_reg(REG_COEF0, 32'h7FFF_FFFF);
        write_reg(REG_SERIES, 32'd255);              // pack voltage clamps
        send_tick(20'sd123);
        drain();
    endtask

    // Phases of random settings; even ones look like a real cell, odd ones are wild.
    task automatic test_random_phases();
        int p;
        int n;
        for (p = 0; p < 8; p++)
        begin
            drain();
            if (p % 2 == 0)
            begin
                load_curve($urandom_range(163840, 275251),
                           int'($urandom_range(1 << 17)) - (1 << 16),
                           int'($urandom_range(1 << 15)) - (1 << 14),
                           int'($urandom_range(1 << 13)) - (1 << 12));
                write_reg(REG_SERIES, $urandom_range(1, 16));
                write_reg(REG_GAIN, $urandom_range(1 << 24));
                write_reg(REG_CAP_PP, $urandom_range(1 << 20, 1 << 24));
                write_reg(REG_INIT_DEPTH, $urandom_range(100 << 24));
            end
            else
            begin
                load_curve(rand_word(), rand_word(), rand_word(), rand_word());
                write_reg(REG_SERIES, $urandom_range(255));
                write_reg(REG_GAIN, rand_word());
                write_reg(REG_CAP_PP, rand_word());
                // sometimes carry the depth over from the last phase
                if ($urandom_range(1))
                    write_reg(REG_INIT_DEPTH, rand_word());
            end
            for (n = 0; n < 40; n++)
                send_tick(rand_current());
        end
        drain();
    endtask

    // Receiver holds off for a long stretch while ticks keep coming: the block fills
    // and must stall its input, then everything flows out in order.
    task automatic test_output_hold_off();
        int n;
        hold_req = 1'b1;
        for (n = 0; n < 30; n++)
            send_tick(rand_current());
        drain();
    endtask

    // No idling on either side: beats back to back at full rate.
    task automatic test_full_rate();
        int n;
        no_gaps = 1'b1;
        for (n = 0; n < 40; n++)
            send_tick(rand_current());
        drain();
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < NUM_COEF; i++)
            curve_coef[i] = '0;
        cells_in_series = 8'd1;
        gain_per_ma     = '0;
        ah_per_percent  = '0;
        tracked_depth   = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_nominal_cell();
        test_depth_clamp();
        test_degenerate_settings();
        test_random_phases();
        test_output_hold_off();
        test_full_rate();

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

[files.f]
sv/bcv_pkg.sv
sv/bcv_cfg_regs.sv
sv/bcv_datapath.sv
sv/bcv_ctrl.sv
sv/battery_charge_and_voltage_model.sv
tb/sv/tb_top.sv
